### sv/pils_pkg.sv
// ----------------------------------------------------------------------------
// pils_pkg
// Shared types, constants and helpers for the pixel indicator LSB stego unit.
// ----------------------------------------------------------------------------
package pils_pkg;

  localparam int PIX_W        = 8;
  localparam int COL_W        = 14;
  localparam int WIDTH_W      = 15;
  localparam int MAX_KEY_BITS = 64;
  localparam int KEY_POS_W    = $clog2(MAX_KEY_BITS);
  localparam int KLEN_W       = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(16384);
  localparam logic [WIDTH_W-1:0] WIDTH_RST   = WIDTH_W'(1);
  localparam logic [KLEN_W-1:0]  KLEN_MAX    = KLEN_W'(MAX_KEY_BITS);
  localparam logic [KLEN_W-1:0]  KLEN_RST    = KLEN_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd3;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_EMBED,
    OP_EXTRACT
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] red_in;
    logic             payload_bit;
    logic             carries;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] red_out;
    logic             found_bit;
    logic             found_valid;
  } pix_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             payload_bit;
    op_t              op;
    logic [1:0]       carrier;
  } work_t;

  // carrier channel from indicator channel and (indicator lsb ^ key bit)
  function automatic logic [1:0] carrier_sel(input logic [1:0] sel, input logic pick);
    logic [1:0] c;
    case (sel)
      CH_BLUE:  c = pick ? CH_RED   : CH_GREEN;
      CH_GREEN: c = pick ? CH_BLUE  : CH_RED;
      default:  c = pick ? CH_GREEN : CH_BLUE;
    endcase
    return c;
  endfunction

endpackage

### sv/pixel_indicator_lsb_stego_unit.sv
// ----------------------------------------------------------------------------
// pixel_indicator_lsb_stego_unit
// Pixel-indicator LSB embed/extract on a BGR pixel stream, queue interfaces.
// ----------------------------------------------------------------------------
// A pushed pixel is written to the queue, then to the output register.
// Throughput: one pixel per cycle while popped; the two-entry queue and output
// register keep push open for two more pixels while a result waits for pop.
// Reset (rst_n, synchronous): queues empty, column and key position zero,
// mode embed, width 1, key bits zero, key length 8.
module pixel_indicator_lsb_stego_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  pils_pkg::pix_in_t               in_pixel,
  output logic                            empty,
  input  logic                            pop,
  output pils_pkg::pix_out_t              out_pixel,
  input  logic                            cfg_we,
  input  logic [pils_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pils_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic            acc;
  logic            q_full, q_empty, q_rd;
  pils_pkg::work_t wr_item, rd_item;

  assign full = q_full;
  assign acc  = push && !q_full;

  pils_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .pix       (in_pixel),
    .item      (wr_item)
  );

  pils_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (acc),
    .wr_item (wr_item),
    .full    (q_full),
    .rd      (q_rd),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  pils_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (rd_item),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .out_pix (out_pixel)
  );

endmodule

### sv/pils_front.sv
// ----------------------------------------------------------------------------
// pils_front
// Config registers, column/key tracking and per-pixel classification.
// ----------------------------------------------------------------------------
module pils_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pils_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pils_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            acc,
  input  pils_pkg::pix_in_t               pix,
  output pils_pkg::work_t                 item
);

  logic                                mode_r;
  logic [pils_pkg::WIDTH_W-1:0]        width_r;
  logic [pils_pkg::MAX_KEY_BITS-1:0]   key_r;
  logic [pils_pkg::KLEN_W-1:0]         klen_r;
  logic [pils_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [1:0]                          mod3_r, mod3_nxt;
  logic [pils_pkg::KEY_POS_W-1:0]      key_pos_r, key_pos_nxt;

  logic [pils_pkg::WIDTH_W-1:0]        w_eff;
  logic [pils_pkg::KLEN_W-1:0]         klen_eff;
  logic [pils_pkg::WIDTH_W-1:0]        col_inc;
  logic [pils_pkg::KLEN_W-1:0]         kpos_inc;
  logic                                ind_lsb;
  logic                                kbit;

  always_comb begin
    if (width_r == '0) begin
      w_eff = pils_pkg::WIDTH_W'(1);
    end else if (width_r > pils_pkg::WIDTH_LIMIT) begin
      w_eff = pils_pkg::WIDTH_LIMIT;
    end else begin
      w_eff = width_r;
    end
    if (klen_r == '0) begin
      klen_eff = pils_pkg::KLEN_W'(1);
    end else if (klen_r > pils_pkg::KLEN_MAX) begin
      klen_eff = pils_pkg::KLEN_MAX;
    end else begin
      klen_eff = klen_r;
    end
  end

  assign col_inc  = {1'b0, col_r} + pils_pkg::WIDTH_W'(1);
  assign kpos_inc = pils_pkg::KLEN_W'(key_pos_r) + pils_pkg::KLEN_W'(1);
  assign kbit     = key_r[key_pos_r];

  always_comb begin
    case (mod3_r)
      pils_pkg::CH_BLUE:  ind_lsb = pix.blue_in[0];
      pils_pkg::CH_GREEN: ind_lsb = pix.green_in[0];
      default:            ind_lsb = pix.red_in[0];
    endcase
  end

  always_comb begin
    item.blue        = pix.blue_in;
    item.green       = pix.green_in;
    item.red         = pix.red_in;
    item.payload_bit = pix.payload_bit;
    item.carrier     = pils_pkg::carrier_sel(mod3_r, ind_lsb ^ kbit);
    if (!pix.carries) begin
      item.op = pils_pkg::OP_PASS;
    end else if (mode_r == pils_pkg::MODE_EXTRACT) begin
      item.op = pils_pkg::OP_EXTRACT;
    end else begin
      item.op = pils_pkg::OP_EMBED;
    end
  end

  always_comb begin
    col_nxt     = col_r;
    mod3_nxt    = mod3_r;
    key_pos_nxt = key_pos_r;
    if (acc) begin
      if (col_inc >= w_eff) begin
        col_nxt  = '0;
        mod3_nxt = pils_pkg::CH_BLUE;
      end else begin
        col_nxt  = col_inc[pils_pkg::COL_W-1:0];
        mod3_nxt = (mod3_r == pils_pkg::CH_RED) ? pils_pkg::CH_BLUE : mod3_r + 2'd1;
      end
      if (pix.carries) begin
        key_pos_nxt = (kpos_inc >= klen_eff) ? '0 : kpos_inc[pils_pkg::KEY_POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pils_pkg::MODE_EMBED;
      width_r   <= pils_pkg::WIDTH_RST;
      key_r     <= '0;
      klen_r    <= pils_pkg::KLEN_RST;
      col_r     <= '0;
      mod3_r    <= pils_pkg::CH_BLUE;
      key_pos_r <= '0;
    end else begin
      col_r     <= col_nxt;
      mod3_r    <= mod3_nxt;
      key_pos_r <= key_pos_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pils_pkg::REG_MODE:     mode_r  <= cfg_data[0];
          pils_pkg::REG_WIDTH:    width_r <= cfg_data[pils_pkg::WIDTH_W-1:0];
          pils_pkg::REG_KEY_BITS: key_r   <= cfg_data[pils_pkg::MAX_KEY_BITS-1:0];
          pils_pkg::REG_KEY_LEN:  klen_r  <= cfg_data[pils_pkg::KLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(col_r) && $stable(key_pos_r) && $stable(mod3_r))
    else $error("position moved without a transfer");

  a_key_on_carry: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !pix.carries |=> $stable(key_pos_r))
    else $error("key position moved on non-carrying pixel");

  a_mod3_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    col_r == '0 |-> mod3_r == pils_pkg::CH_BLUE)
    else $error("column phase out of step at column zero");

endmodule

### sv/pils_queue.sv
// ----------------------------------------------------------------------------
// pils_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pils_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  pils_pkg::work_t wr_item,
  output logic            full,
  input  logic            rd,
  output pils_pkg::work_t rd_item,
  output logic            empty
);

  pils_pkg::work_t                 mem_r [pils_pkg::QDEPTH];
  logic [pils_pkg::QPTR_W-1:0]     wptr_r, rptr_r;
  logic [pils_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_wr, do_rd;

  assign full    = (cnt_r == pils_pkg::QCNT_W'(pils_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + pils_pkg::QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - pils_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wptr_r <= wptr_r + pils_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + pils_pkg::QPTR_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pils_pkg::QCNT_W'(pils_pkg::QDEPTH))
    else $error("queue over capacity");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || full |-> wptr_r == rptr_r)
    else $error("queue pointers disagree with count");

  a_wr_grow: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> cnt_r == $past(cnt_r) + pils_pkg::QCNT_W'(1))
    else $error("queue count did not grow on write");

endmodule

### sv/pils_back.sv
// ----------------------------------------------------------------------------
// pils_back
// Applies embed/extract to a classified item into the output register.
// ----------------------------------------------------------------------------
module pils_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pils_pkg::work_t    q_item,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output pils_pkg::pix_out_t out_pix
);

  logic               valid_r;
  pils_pkg::pix_out_t out_r, res;
  logic               car_lsb;

  assign q_rd    = !q_empty && (!valid_r || pop);
  assign empty   = !valid_r;
  assign out_pix = out_r;

  always_comb begin
    case (q_item.carrier)
      pils_pkg::CH_BLUE:  car_lsb = q_item.blue[0];
      pils_pkg::CH_GREEN: car_lsb = q_item.green[0];
      default:            car_lsb = q_item.red[0];
    endcase
  end

  always_comb begin
    res.blue_out    = q_item.blue;
    res.green_out   = q_item.green;
    res.red_out     = q_item.red;
    res.found_bit   = 1'b0;
    res.found_valid = 1'b0;
    case (q_item.op)
      pils_pkg::OP_EMBED: begin
        case (q_item.carrier)
          pils_pkg::CH_BLUE:  res.blue_out[0]  = q_item.payload_bit;
          pils_pkg::CH_GREEN: res.green_out[0] = q_item.payload_bit;
          pils_pkg::CH_RED:   res.red_out[0]   = q_item.payload_bit;
          default: ;
        endcase
      end
      pils_pkg::OP_EXTRACT: begin
        res.found_bit   = car_lsb;
        res.found_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  a_found_op: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd && q_item.op != pils_pkg::OP_EXTRACT |=> !out_r.found_valid && !out_r.found_bit)
    else $error("found flag outside extract");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |=> valid_r)
    else $error("output not valid after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop |-> !q_rd)
    else $error("output overwritten before transfer");

endmodule
